>>> sv/tdwt_pkg.sv
// shared constants, codes and types of the task dispatcher
package tdwt_pkg;

  localparam int MAX_MAP_TASKS    = 64;
  localparam int MAX_REDUCE_TASKS = 16;
  localparam int STAMP_BITS       = 32;

  localparam int TIMEOUT_RESET = 500;

  // index and count widths
  localparam int MIDX_W = (MAX_MAP_TASKS > 1) ? $clog2(MAX_MAP_TASKS) : 1;
  localparam int RIDX_W = (MAX_REDUCE_TASKS > 1) ? $clog2(MAX_REDUCE_TASKS) : 1;
  localparam int SIDX_W = (MIDX_W > RIDX_W) ? MIDX_W : RIDX_W;
  localparam int MCNT_W = $clog2(MAX_MAP_TASKS + 1);
  localparam int RCNT_W = $clog2(MAX_REDUCE_TASKS + 1);
  localparam int SCNT_W = (MCNT_W > RCNT_W) ? MCNT_W : RCNT_W;

  // stamp memory: map entries first, reduce entries after them
  localparam int RAM_DEPTH = MAX_MAP_TASKS + MAX_REDUCE_TASKS;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);

  // field widths of the ports
  localparam int CMD_W   = 2;
  localparam int KIND_W  = 2;
  localparam int INDEX_W = 6;
  localparam int CFGI_W  = 2;
  localparam int CFGD_W  = 32;
  localparam int MCFG_W  = 7;
  localparam int RCFG_W  = 5;
  localparam int TMO_W   = 32;

  // commands
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ASK    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SUBMIT = 2'd2;

  // task kinds on submit
  localparam logic [KIND_W-1:0] TK_MAP    = 2'd0;
  localparam logic [KIND_W-1:0] TK_REDUCE = 2'd1;

  // reply kinds
  localparam logic [KIND_W-1:0] RK_NONE   = 2'd0;
  localparam logic [KIND_W-1:0] RK_MAP    = 2'd1;
  localparam logic [KIND_W-1:0] RK_REDUCE = 2'd2;

  // register indexes
  localparam logic [CFGI_W-1:0] REG_MAP_COUNT    = 2'd0;
  localparam logic [CFGI_W-1:0] REG_REDUCE_COUNT = 2'd1;
  localparam logic [CFGI_W-1:0] REG_TIMEOUT      = 2'd2;

  // stamp memory write port
  typedef struct packed {
    logic                  we;
    logic [RAM_AW-1:0]     addr;
    logic [STAMP_BITS-1:0] data;
  } stamp_wr_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_RESP = 3'b100
  } state_t;

endpackage

>>> sv/tdwt_stamp_ram.sv
// start-stamp memory, one write port and one registered read port
module tdwt_stamp_ram
  import tdwt_pkg::*;
(
  input  logic                  clk,
  input  stamp_wr_t             wr,
  input  logic [RAM_AW-1:0]     raddr,
  output logic [STAMP_BITS-1:0] rdata
);

  logic [STAMP_BITS-1:0] mem [RAM_DEPTH];
  logic [STAMP_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> sv/tdwt_age_unit.sv
// shared age check: clock minus stamp, modulo stamp width, against the timeout
module tdwt_age_unit
  import tdwt_pkg::*;
(
  input  logic [STAMP_BITS-1:0] clock_now,
  input  logic [STAMP_BITS-1:0] stamp,
  input  logic [TMO_W-1:0]      timeout,
  output logic                  aged
);

  logic [STAMP_BITS-1:0] age;

  assign age  = clock_now - stamp;
  assign aged = 64'(age) > 64'(timeout);

endmodule

>>> sv/task_dispatcher_with_timeout.sv
// two-phase task dispatcher with timeout reissue: sequencer, flags and output register
// flow: tick, submit and unused commands go from idle to the result state, then to the
//   output register; an ask scans the current phase, reading stamps and checking flags, up to
//   the first free task or the end of the task count (at most 64 map, 16 reduce), then goes to
//   the result state; an ask after both phases are done goes there directly
// throughput: one request at a time, set by the scan over the stamp memory read port
// reset: sync active low; flags, counts, clock clear, timeout to 500; stamps, payloads unknown
module task_dispatcher_with_timeout
  import tdwt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [KIND_W-1:0]  in_task_kind,
  input  logic [INDEX_W-1:0] in_task_index,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [KIND_W-1:0]  out_reply_kind,
  output logic [INDEX_W-1:0] out_reply_index,
  output logic               out_submit_ok,
  output logic               out_all_done,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFGI_W-1:0]  cfg_index,
  input  logic [CFGD_W-1:0]  cfg_data
);

  // sequencer state
  state_t state_r, state_nxt;

  // configuration registers
  logic [MCFG_W-1:0] map_count_r, map_count_nxt;
  logic [RCFG_W-1:0] red_count_r, red_count_nxt;
  logic [TMO_W-1:0]  timeout_r, timeout_nxt;

  // dispatcher state
  logic [STAMP_BITS-1:0]       tick_r, tick_nxt;
  logic [MAX_MAP_TASKS-1:0]    m_asg_r, m_asg_nxt;
  logic [MAX_MAP_TASKS-1:0]    m_cmp_r, m_cmp_nxt;
  logic [MAX_REDUCE_TASKS-1:0] r_asg_r, r_asg_nxt;
  logic [MAX_REDUCE_TASKS-1:0] r_cmp_r, r_cmp_nxt;
  logic [MCNT_W-1:0]           map_done_r, map_done_nxt;
  logic [RCNT_W-1:0]           red_done_r, red_done_nxt;
  logic                        fin_r, fin_nxt;

  // scan control
  logic              phase_r, phase_nxt;       // 0 map, 1 reduce
  logic [SCNT_W-1:0] scount_r, scount_nxt;     // entries to scan in this phase
  logic [SCNT_W-1:0] iss_idx_r, iss_idx_nxt;   // next entry to read
  logic              ev_valid_r, ev_valid_nxt; // entry under check this cycle
  logic [SIDX_W-1:0] ev_idx_r, ev_idx_nxt;
  logic              cand_valid_r, cand_valid_nxt;
  logic [SIDX_W-1:0] cand_idx_r, cand_idx_nxt;

  // pending result
  logic [KIND_W-1:0]  resp_kind_r, resp_kind_nxt;
  logic [INDEX_W-1:0] resp_idx_r, resp_idx_nxt;
  logic               resp_ok_r, resp_ok_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]  out_kind_r, out_kind_nxt;
  logic [INDEX_W-1:0] out_idx_r, out_idx_nxt;
  logic               out_ok_r, out_ok_nxt;
  logic               out_done_r, out_done_nxt;

  // helpers
  logic [MCNT_W-1:0]     mcount;
  logic [RCNT_W-1:0]     rcount;
  logic                  in_acc;
  logic                  iss_more;
  logic [SIDX_W-1:0]     iss_idx;
  logic                  ev_asg;
  logic                  ev_cmp;
  logic                  aged;
  logic [STAMP_BITS-1:0] stamp_rdata;
  logic [RAM_AW-1:0]     stamp_raddr;
  stamp_wr_t             stamp_wr;

  // task counts above the maximum saturate
  always_comb begin
    if (32'(map_count_r) > 32'(MAX_MAP_TASKS)) begin
      mcount = MCNT_W'(MAX_MAP_TASKS);
    end else begin
      mcount = MCNT_W'(map_count_r);
    end
    if (32'(red_count_r) > 32'(MAX_REDUCE_TASKS)) begin
      rcount = RCNT_W'(MAX_REDUCE_TASKS);
    end else begin
      rcount = RCNT_W'(red_count_r);
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // read side of the scan: one stamp read issued per cycle while entries remain
  assign iss_more = (iss_idx_r != scount_r);
  assign iss_idx  = SIDX_W'(iss_idx_r);
  assign stamp_raddr = phase_r ? (RAM_AW'(MAX_MAP_TASKS) + RAM_AW'(iss_idx))
                               : RAM_AW'(iss_idx);

  // flags of the entry under check
  assign ev_asg = phase_r ? r_asg_r[RIDX_W'(ev_idx_r)] : m_asg_r[MIDX_W'(ev_idx_r)];
  assign ev_cmp = phase_r ? r_cmp_r[RIDX_W'(ev_idx_r)] : m_cmp_r[MIDX_W'(ev_idx_r)];

  tdwt_stamp_ram u_stamp_ram (
    .clk   (clk),
    .wr    (stamp_wr),
    .raddr (stamp_raddr),
    .rdata (stamp_rdata)
  );

  tdwt_age_unit u_age_unit (
    .clock_now (tick_r),
    .stamp     (stamp_rdata),
    .timeout   (timeout_r),
    .aged      (aged)
  );

  always_comb begin
    state_nxt      = state_r;
    map_count_nxt  = map_count_r;
    red_count_nxt  = red_count_r;
    timeout_nxt    = timeout_r;
    tick_nxt       = tick_r;
    m_asg_nxt      = m_asg_r;
    m_cmp_nxt      = m_cmp_r;
    r_asg_nxt      = r_asg_r;
    r_cmp_nxt      = r_cmp_r;
    map_done_nxt   = map_done_r;
    red_done_nxt   = red_done_r;
    fin_nxt        = fin_r;
    phase_nxt      = phase_r;
    scount_nxt     = scount_r;
    iss_idx_nxt    = iss_idx_r;
    ev_valid_nxt   = 1'b0;
    ev_idx_nxt     = ev_idx_r;
    cand_valid_nxt = cand_valid_r;
    cand_idx_nxt   = cand_idx_r;
    resp_kind_nxt  = resp_kind_r;
    resp_idx_nxt   = resp_idx_r;
    resp_ok_nxt    = resp_ok_r;
    out_valid_nxt  = out_valid_r;
    out_kind_nxt   = out_kind_r;
    out_idx_nxt    = out_idx_r;
    out_ok_nxt     = out_ok_r;
    out_done_nxt   = out_done_r;
    stamp_wr.we    = 1'b0;
    stamp_wr.addr  = phase_r ? (RAM_AW'(MAX_MAP_TASKS) + RAM_AW'(ev_idx_r))
                             : RAM_AW'(ev_idx_r);
    stamp_wr.data  = tick_r;

    // configuration writes, to be issued only while idle; the block itself does not enforce it
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAP_COUNT:    map_count_nxt = MCFG_W'(cfg_data);
        REG_REDUCE_COUNT: red_count_nxt = RCFG_W'(cfg_data);
        REG_TIMEOUT:      timeout_nxt   = TMO_W'(cfg_data);
        default: ;
      endcase
    end

    // output register drains independently of the sequencer
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          resp_kind_nxt = RK_NONE;
          resp_idx_nxt  = '0;
          resp_ok_nxt   = 1'b0;
          state_nxt     = S_RESP;
          unique case (in_command)
            CMD_TICK: begin
              tick_nxt = tick_r + 1'b1;
            end
            CMD_ASK: begin
              // pick the phase, or mark everything finished
              iss_idx_nxt    = '0;
              cand_valid_nxt = 1'b0;
              if (32'(map_done_r) < 32'(mcount)) begin
                phase_nxt  = 1'b0;
                scount_nxt = SCNT_W'(mcount);
                state_nxt  = S_SCAN;
              end else if (32'(red_done_r) < 32'(rcount)) begin
                phase_nxt  = 1'b1;
                scount_nxt = SCNT_W'(rcount);
                state_nxt  = S_SCAN;
              end else begin
                fin_nxt = 1'b1;
              end
            end
            CMD_SUBMIT: begin
              // completed only once; a repeat submit is still accepted
              if (in_task_kind == TK_MAP && 32'(in_task_index) < 32'(mcount)) begin
                resp_ok_nxt = 1'b1;
                if (!m_cmp_r[MIDX_W'(in_task_index)]) begin
                  m_cmp_nxt[MIDX_W'(in_task_index)] = 1'b1;
                  map_done_nxt = map_done_r + 1'b1;
                end
              end else if (in_task_kind == TK_REDUCE &&
                           32'(in_task_index) < 32'(rcount)) begin
                resp_ok_nxt = 1'b1;
                if (!r_cmp_r[RIDX_W'(in_task_index)]) begin
                  r_cmp_nxt[RIDX_W'(in_task_index)] = 1'b1;
                  red_done_nxt = red_done_r + 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        // issue stage
        if (iss_more) begin
          iss_idx_nxt  = iss_idx_r + 1'b1;
          ev_valid_nxt = 1'b1;
          ev_idx_nxt   = iss_idx;
        end
        // check stage
        if (ev_valid_r && !ev_asg && !ev_cmp) begin
          // lowest free task wins at once: assign and stamp it
          stamp_wr.we  = 1'b1;
          ev_valid_nxt = 1'b0;
          if (phase_r) begin
            r_asg_nxt[RIDX_W'(ev_idx_r)] = 1'b1;
          end else begin
            m_asg_nxt[MIDX_W'(ev_idx_r)] = 1'b1;
          end
          resp_kind_nxt = phase_r ? RK_REDUCE : RK_MAP;
          resp_idx_nxt  = INDEX_W'(ev_idx_r);
          state_nxt     = S_RESP;
        end else if (ev_valid_r) begin
          // remember the lowest timed-out task as fallback
          if (ev_asg && !ev_cmp && aged && !cand_valid_r) begin
            cand_valid_nxt = 1'b1;
            cand_idx_nxt   = ev_idx_r;
          end
        end else if (!iss_more) begin
          // scan over with no free task: reissue the fallback if any
          if (cand_valid_r) begin
            stamp_wr.we   = 1'b1;
            stamp_wr.addr = phase_r ? (RAM_AW'(MAX_MAP_TASKS) + RAM_AW'(cand_idx_r))
                                    : RAM_AW'(cand_idx_r);
            resp_kind_nxt = phase_r ? RK_REDUCE : RK_MAP;
            resp_idx_nxt  = INDEX_W'(cand_idx_r);
          end
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        // hand the result to the output register once it has room
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = resp_kind_r;
          out_idx_nxt   = resp_idx_r;
          out_ok_nxt    = resp_ok_r;
          out_done_nxt  = fin_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      map_count_r  <= '0;
      red_count_r  <= '0;
      timeout_r    <= TMO_W'(TIMEOUT_RESET);
      tick_r       <= '0;
      m_asg_r      <= '0;
      m_cmp_r      <= '0;
      r_asg_r      <= '0;
      r_cmp_r      <= '0;
      map_done_r   <= '0;
      red_done_r   <= '0;
      fin_r        <= 1'b0;
      phase_r      <= 1'b0;
      scount_r     <= '0;
      iss_idx_r    <= '0;
      ev_valid_r   <= 1'b0;
      cand_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      map_count_r  <= map_count_nxt;
      red_count_r  <= red_count_nxt;
      timeout_r    <= timeout_nxt;
      tick_r       <= tick_nxt;
      m_asg_r      <= m_asg_nxt;
      m_cmp_r      <= m_cmp_nxt;
      r_asg_r      <= r_asg_nxt;
      r_cmp_r      <= r_cmp_nxt;
      map_done_r   <= map_done_nxt;
      red_done_r   <= red_done_nxt;
      fin_r        <= fin_nxt;
      phase_r      <= phase_nxt;
      scount_r     <= scount_nxt;
      iss_idx_r    <= iss_idx_nxt;
      ev_valid_r   <= ev_valid_nxt;
      cand_valid_r <= cand_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ev_idx_r    <= ev_idx_nxt;
    cand_idx_r  <= cand_idx_nxt;
    resp_kind_r <= resp_kind_nxt;
    resp_idx_r  <= resp_idx_nxt;
    resp_ok_r   <= resp_ok_nxt;
    out_kind_r  <= out_kind_nxt;
    out_idx_r   <= out_idx_nxt;
    out_ok_r    <= out_ok_nxt;
    out_done_r  <= out_done_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_reply_kind  = out_kind_r;
  assign out_reply_index = out_idx_r;
  assign out_submit_ok   = out_ok_r;
  assign out_all_done    = out_done_r;

  // finished flag is sticky
  a_fin_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r |=> fin_r)
    else $error("finished flag dropped");

  // a map task handed out is marked assigned
  a_map_assigned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESP && resp_kind_r == RK_MAP) |-> m_asg_r[MIDX_W'(resp_idx_r)])
    else $error("map task replied without assigned flag");

  // the check stage only runs inside a scan
  a_ev_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ev_valid_r |-> state_r == S_SCAN)
    else $error("scan check outside scan");

  // done counts stay within the task maximum
  a_done_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(map_done_r) <= 32'(MAX_MAP_TASKS) && 32'(red_done_r) <= 32'(MAX_REDUCE_TASKS))
    else $error("done count beyond task maximum");

endmodule
